// File: design/assert_macros.svh
// Assertion macros used by the keep-top-n-extremes core.
// Depends on nothing; the including module provides clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define KTE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define KTE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/kte_pkg.sv
// Shared constants and types for the keep-top-n-extremes block.
// Depends on nothing; kte_ifs, kte_cfg, kte_weigh and the core use it by scoped names.
`timescale 1ns / 1ps

package kte_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int DATA_W       = 16;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  localparam logic [1:0] REG_SELECT_COUNT  = 2'd0;
  localparam logic [1:0] REG_KEEP_SMALLEST = 2'd1;
  localparam logic [1:0] REG_LINK_WEIGHT   = 2'd2;

  typedef struct packed {
    logic [6:0]               select_count;
    logic                     keep_smallest;
    logic signed [DATA_W-1:0] link_weight;
  } cfg_t;

endpackage

// File: design/kte_ifs.sv
// Valid/ready channel interfaces for element requests and kept results.
// Depends on kte_pkg.
`timescale 1ns / 1ps

interface kte_elem_if;
  logic                              valid;
  logic                              ready;
  logic signed [kte_pkg::DATA_W-1:0] activity;
  logic                              final_element;

  modport source (output valid, output activity, output final_element, input ready);
  modport sink (input valid, input activity, input final_element, output ready);
endinterface

interface kte_kept_if;
  logic                              valid;
  logic                              ready;
  logic signed [kte_pkg::DATA_W-1:0] kept_value;
  logic [kte_pkg::IDX_W-1:0]         position;
  logic                              end_of_run;

  modport source (output valid, output kept_value, output position, output end_of_run,
                  input ready);
  modport sink (input valid, input kept_value, input position, input end_of_run,
                output ready);
endinterface

// File: design/kte_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module kte_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/kte_cfg.sv
// APB-style configuration registers: select count, mode and link weight.
// Depends on kte_pkg.
`timescale 1ns / 1ps

module kte_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kte_pkg::PADDR_W-1:0]  paddr,
  input  logic [kte_pkg::PDATA_W-1:0]  pwdata,
  output logic [kte_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output kte_pkg::cfg_t                cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.select_count  <= 7'd1;
      cfg.keep_smallest <= 1'b0;
      cfg.link_weight   <= 16'sd4096;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        kte_pkg::REG_SELECT_COUNT:  cfg.select_count  <= pwdata[6:0];
        kte_pkg::REG_KEEP_SMALLEST: cfg.keep_smallest <= pwdata[0];
        kte_pkg::REG_LINK_WEIGHT:   cfg.link_weight   <= $signed(pwdata[15:0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      kte_pkg::REG_SELECT_COUNT:  prdata = {25'd0, cfg.select_count};
      kte_pkg::REG_KEEP_SMALLEST: prdata = {31'd0, cfg.keep_smallest};
      kte_pkg::REG_LINK_WEIGHT:   prdata = {{16{cfg.link_weight[15]}}, cfg.link_weight};
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: design/kte_weigh.sv
// Gain stage: registered Q8.24 product of Q4.12 operands, then round half up to Q4.12 and saturate.
// Depends on kte_pkg.
`timescale 1ns / 1ps

module kte_weigh (
  input  logic                              clk,
  input  logic                              load,
  input  logic signed [kte_pkg::DATA_W-1:0] act,
  input  logic signed [kte_pkg::DATA_W-1:0] weight,
  output logic signed [kte_pkg::DATA_W-1:0] result
);

  logic signed [31:0] prod;
  logic signed [32:0] biased;
  logic signed [20:0] quot;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= act * weight;
    end
  end

  // Adding half an LSB and dropping twelve bits floors, so halves round up.
  assign biased = {prod[31], prod} + 33'sd2048;
  assign quot   = biased[32:12];

  always_comb begin
    if (!quot[20] && (quot[19:15] != 5'b00000)) begin
      result = 16'sh7FFF;
    end else if (quot[20] && (quot[19:15] != 5'b11111)) begin
      result = 16'sh8000;
    end else begin
      result = quot[15:0];
    end
  end

endmodule

// File: design/keep_top_n_extremes_core.sv
// Keeps the select_count largest (or smallest) elements of a loaded vector and
// emits every element in order, a kept one scaled by link_weight, any other as
// zero. Element requests are accepted only while loading, until final_element or
// a full store of 64. Selection then runs min(select_count, n) passes over the
// element RAM, the single read port yielding one entry per cycle, and emission
// reads, weighs and presents each element in turn, holding while the output is
// not taken. Each RAM entry holds an element together with its chosen mark, so
// loading an element clears it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keep_top_n_extremes_core (
  input  logic                        clk,
  input  logic                        rst,
  kte_elem_if.sink                    elem,
  kte_kept_if.source                  kept,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kte_pkg::PADDR_W-1:0] paddr,
  input  logic [kte_pkg::PDATA_W-1:0] pwdata,
  output logic [kte_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_MARK,
    ST_EMIT_RD,
    ST_EMIT_MUL,
    ST_EMIT_OUT
  } state_t;

  state_t                             state;
  kte_pkg::cfg_t                      cfg;
  logic [kte_pkg::CNT_W-1:0]          cnt;
  logic [kte_pkg::CNT_W-1:0]          n_len;
  logic [kte_pkg::CNT_W-1:0]          scan_idx;
  logic [kte_pkg::CNT_W-1:0]          passes;
  logic [kte_pkg::CNT_W-1:0]          len_next;
  logic [kte_pkg::CNT_W-1:0]          keep_next;
  logic [kte_pkg::IDX_W-1:0]          emit_idx;
  logic [kte_pkg::IDX_W-1:0]          best;
  logic [kte_pkg::IDX_W-1:0]          rd_idx;
  logic signed [kte_pkg::DATA_W-1:0]  best_val;
  logic signed [kte_pkg::DATA_W-1:0]  rdata;
  logic signed [kte_pkg::DATA_W-1:0]  weighed;
  logic                               found;
  logic                               rd_vld;
  logic                               rd_mark;
  logic                               elem_acc;
  logic                               last_elem;
  logic                               ram_we;
  logic [kte_pkg::IDX_W-1:0]          ram_waddr;
  logic [kte_pkg::DATA_W:0]           ram_wdata;
  logic [kte_pkg::DATA_W:0]           ram_rdata;
  logic                               ram_re;
  logic [kte_pkg::IDX_W-1:0]          ram_raddr;
  logic                               better;
  logic                               emit_last;
  logic                               emit_fire;
  logic                               out_valid;
  logic signed [kte_pkg::DATA_W-1:0]  out_value;
  logic [kte_pkg::IDX_W-1:0]          out_pos;
  logic                               out_end;

  kte_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kte_ram #(
    .DEPTH (kte_pkg::MAX_ELEMENTS),
    .WIDTH (kte_pkg::DATA_W + 1)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kte_weigh u_weigh (
    .clk    (clk),
    .load   (state == ST_EMIT_MUL),
    .act    (rdata),
    .weight (cfg.link_weight),
    .result (weighed)
  );

  assign elem.ready = (state == ST_LOAD);
  assign elem_acc   = elem.valid && elem.ready;
  assign len_next   = cnt + 1'b1;
  assign last_elem  = elem.final_element ||
                      (len_next == kte_pkg::CNT_W'(kte_pkg::MAX_ELEMENTS));
  assign keep_next  = (cfg.select_count < len_next) ? cfg.select_count : len_next;

  assign ram_we    = elem_acc || ((state == ST_MARK) && found);
  assign ram_waddr = (state == ST_MARK) ? best : cnt[kte_pkg::IDX_W-1:0];
  assign ram_wdata = (state == ST_MARK) ? {1'b1, best_val} : {1'b0, elem.activity};
  assign rdata     = ram_rdata[kte_pkg::DATA_W-1:0];
  assign rd_mark   = ram_rdata[kte_pkg::DATA_W];

  assign ram_re    = ((state == ST_SCAN) && (scan_idx < n_len)) || (state == ST_EMIT_RD);
  assign ram_raddr = (state == ST_SCAN) ? scan_idx[kte_pkg::IDX_W-1:0] : emit_idx;
  assign better    = cfg.keep_smallest ? (rdata < best_val) : (rdata > best_val);
  assign emit_last = ({1'b0, emit_idx} + 1'b1) == n_len;
  assign emit_fire = (state == ST_EMIT_OUT) && (!out_valid || kept.ready);

  assign kept.valid      = out_valid;
  assign kept.kept_value = out_value;
  assign kept.position   = out_pos;
  assign kept.end_of_run = out_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      cnt       <= '0;
      n_len     <= '0;
      found     <= 1'b0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SCAN) && (scan_idx < n_len);
      rd_idx <= scan_idx[kte_pkg::IDX_W-1:0];
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (kept.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (elem_acc) begin
            if (last_elem) begin
              cnt      <= '0;
              n_len    <= len_next;
              passes   <= keep_next;
              scan_idx <= '0;
              found    <= 1'b0;
              emit_idx <= '0;
              state    <= (keep_next == '0) ? ST_EMIT_RD : ST_SCAN;
            end else begin
              cnt <= len_next;
            end
          end
        end
        ST_SCAN: begin
          if (rd_vld && !rd_mark && (!found || better)) begin
            found    <= 1'b1;
            best     <= rd_idx;
            best_val <= rdata;
          end
          if (scan_idx == n_len) begin
            state <= ST_MARK;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_MARK: begin
          passes <= passes - 1'b1;
          if (passes == kte_pkg::CNT_W'(1)) begin
            state <= ST_EMIT_RD;
          end else begin
            scan_idx <= '0;
            found    <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_MUL;
        end
        ST_EMIT_MUL: begin
          state <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          if (emit_fire) begin
            out_value <= rd_mark ? weighed : '0;
            out_pos   <= emit_idx;
            out_end   <= emit_last;
            if (emit_last) begin
              state <= ST_LOAD;
            end else begin
              emit_idx <= emit_idx + 1'b1;
              state    <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Every selection pass finds an entry that no earlier pass chose.
  `KTE_ASSERT(a_pass_found, (state == ST_MARK) |-> found, "selection pass found no entry")
  // A chosen entry always lies inside the loaded vector.
  `KTE_ASSERT(a_best_range, (state == ST_MARK) |-> ({1'b0, best} < n_len), "chosen entry out of range")
  // A scan only runs while passes remain, and never more passes than entries.
  `KTE_ASSERT(a_pass_count, (state == ST_SCAN) |-> ((passes != '0) && (passes <= n_len)), "bad pass count")

endmodule

// File: test/keep_top_n_extremes_core_tb.sv
// Self-checking testbench for keep_top_n_extremes_core: drives element requests,
// programs the registers over APB and checks every kept result against a predictor.
// Depends on kte_pkg, the kte_elem_if and kte_kept_if interfaces and the core itself.
`timescale 1ns / 1ps

module keep_top_n_extremes_core_tb;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int IDLE_PERCENT = 6;
  localparam int RANDOM_ITEMS = 250;
  localparam int PHASE_ITEMS  = 50;

  typedef logic signed [kte_pkg::DATA_W-1:0] activity_t;

  typedef struct packed {
    activity_t                 kept_value;
    logic [kte_pkg::IDX_W-1:0] position;
    logic                      end_of_run;
  } kept_result_t;

  typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_EDGES} spread_t;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [kte_pkg::PADDR_W-1:0]  paddr;
  logic [kte_pkg::PDATA_W-1:0]  pwdata;
  logic [kte_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  kte_elem_if elem_if ();
  kte_kept_if kept_if ();

  keep_top_n_extremes_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .elem    (elem_if),
    .kept    (kept_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [6:0]   shadow_select_count;
  logic         shadow_keep_smallest;
  activity_t    shadow_link_weight;
  activity_t    loaded_elements[$];
  kept_result_t expected_kept[$];
  kept_result_t oldest_kept;
  int           errors = 0;
  int           cycles = 0;
  int           requests_sent = 0;
  int           vectors_closed = 0;
  int           results_checked = 0;
  bit           steady_flow = 1'b0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    kept_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      kept_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               expected_kept.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && kept_if.valid && kept_if.ready) begin
      if (expected_kept.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual value %0d position %0d end %0b",
                 $time, kept_if.kept_value, kept_if.position, kept_if.end_of_run);
      end else begin
        oldest_kept = expected_kept.pop_front();
        results_checked++;
        if (kept_if.kept_value !== oldest_kept.kept_value) begin
          errors++;
          $display("%0t: kept_value mismatch at position %0d: expected %0d, actual %0d", $time,
                   oldest_kept.position, oldest_kept.kept_value, kept_if.kept_value);
        end
        if (kept_if.position !== oldest_kept.position) begin
          errors++;
          $display("%0t: position mismatch: expected %0d, actual %0d", $time,
                   oldest_kept.position, kept_if.position);
        end
        if (kept_if.end_of_run !== oldest_kept.end_of_run) begin
          errors++;
          $display("%0t: end_of_run mismatch at position %0d: expected %0b, actual %0b", $time,
                   oldest_kept.position, oldest_kept.end_of_run, kept_if.end_of_run);
        end
      end
    end
  end

  // Q4.12 times Q4.12, rounded half up back to Q4.12 and saturated.
  function automatic activity_t weigh_kept(input activity_t value, input activity_t weight);
    longint scaled;
    scaled = (longint'(value) * longint'(weight) + 64'sd2048) >>> 12;
    if (scaled > 32767) return 16'sh7fff;
    if (scaled < -32768) return 16'sh8000;
    return activity_t'(scaled);
  endfunction

  function automatic void select_extremes();
    bit           chosen[kte_pkg::MAX_ELEMENTS];
    int           count;
    int           keep;
    int           best;
    int           pass;
    int           i;
    bit           found;
    kept_result_t result;
    count = loaded_elements.size();
    keep = (int'(shadow_select_count) < count) ? int'(shadow_select_count) : count;
    for (i = 0; i < kte_pkg::MAX_ELEMENTS; i++) chosen[i] = 1'b0;
    for (pass = 0; pass < keep; pass++) begin
      found = 1'b0;
      best = 0;
      for (i = 0; i < count; i++) begin
        if (!chosen[i]) begin
          if (!found) begin
            found = 1'b1;
            best = i;
          end else if (shadow_keep_smallest ? (loaded_elements[i] < loaded_elements[best])
                                            : (loaded_elements[i] > loaded_elements[best])) begin
            best = i;
          end
        end
      end
      if (found) chosen[best] = 1'b1;
    end
    for (i = 0; i < count; i++) begin
      result.kept_value = chosen[i] ? weigh_kept(loaded_elements[i], shadow_link_weight) : '0;
      result.position = kte_pkg::IDX_W'(i);
      result.end_of_run = (i == count - 1);
      expected_kept.push_back(result);
    end
    loaded_elements.delete();
    vectors_closed++;
  endfunction

  task automatic send_element(input activity_t activity, input logic final_element);
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      elem_if.valid <= 1'b0;
      @(negedge clk);
    end
    elem_if.valid <= 1'b1;
    elem_if.activity <= activity;
    elem_if.final_element <= final_element;
    @(posedge clk);
    while (!elem_if.ready) @(posedge clk);
    requests_sent++;
    loaded_elements.push_back(activity);
    if (final_element || loaded_elements.size() == kte_pkg::MAX_ELEMENTS) select_extremes();
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    elem_if.valid <= 1'b0;
    while (expected_kept.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index,
                                input logic [kte_pkg::PDATA_W-1:0] value);
    logic [kte_pkg::PDATA_W-1:0] mask;
    logic [kte_pkg::PDATA_W-1:0] readback;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (index)
      kte_pkg::REG_SELECT_COUNT: begin
        shadow_select_count = value[6:0];
        mask = 32'h7f;
      end
      kte_pkg::REG_KEEP_SMALLEST: begin
        shadow_keep_smallest = value[0];
        mask = 32'h1;
      end
      kte_pkg::REG_LINK_WEIGHT: begin
        shadow_link_weight = value[kte_pkg::DATA_W-1:0];
        mask = 32'hffff;
      end
      default: begin
        mask = '0;
      end
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    if ((readback & mask) !== (value & mask)) begin
      errors++;
      $display("%0t: register %0d readback: expected 0x%0h, actual 0x%0h", $time, index,
               value & mask, readback & mask);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input int select_count, input bit keep_smallest,
                            input int link_weight);
    wait_for_results();
    write_register(kte_pkg::REG_SELECT_COUNT, kte_pkg::PDATA_W'(select_count));
    write_register(kte_pkg::REG_KEEP_SMALLEST, kte_pkg::PDATA_W'(keep_smallest));
    write_register(kte_pkg::REG_LINK_WEIGHT, kte_pkg::PDATA_W'(link_weight & 32'hffff));
  endtask

  task automatic send_vector(input int values[$]);
    int i;
    for (i = 0; i < values.size(); i++)
      send_element(activity_t'(values[i]), i == values.size() - 1);
  endtask

  function automatic activity_t random_activity(input spread_t spread);
    case (spread)
      SPREAD_FULL: return activity_t'($urandom_range(0, 65535));
      SPREAD_NARROW: return activity_t'(int'($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  task automatic send_random_vector(input int length, input bit mark_final,
                                    input spread_t spread);
    int i;
    for (i = 0; i < length; i++)
      send_element(random_activity(spread), mark_final && (i == length - 1));
  endtask

  task automatic test_reset_defaults();
    send_vector('{32767, -32768, 0, 32767});
    send_vector('{-5});
  endtask

  task automatic test_smallest_and_rounding();
    set_config(3, 1'b1, 2048);
    send_vector('{1, -1, -3, 3, -3});
    set_config(3, 1'b1, -32768);
    send_vector('{-32768, 32767, -1});
    set_config(2, 1'b0, -2048);
    send_vector('{3, 1, -1});
  endtask

  task automatic test_count_extremes();
    set_config(0, 1'b0, 4096);
    send_vector('{7, -8});
    set_config(64, 1'b0, 32767);
    send_vector('{32767, -32768, 16, 1, -1});
  endtask

  task automatic test_full_store();
    set_config(5, 1'b0, 4096);
    send_random_vector(kte_pkg::MAX_ELEMENTS, 1'b0, SPREAD_FULL);
    send_random_vector(1, 1'b1, SPREAD_FULL);
    set_config(64, 1'b1, -4096);
    send_random_vector(kte_pkg::MAX_ELEMENTS, 1'b1, SPREAD_NARROW);
  endtask

  task automatic test_random_vectors();
    int      start_count;
    int      phase_start;
    int      phase;
    int      select_count;
    int      link_weight;
    int      length;
    int      pick;
    spread_t spread;
    start_count = requests_sent;
    phase = 0;
    while (requests_sent - start_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      select_count = (pick == 0) ? 0 : (pick == 1) ? 64 : (pick == 2) ? 1 :
                     (pick < 6) ? $urandom_range(1, 8) : $urandom_range(0, 64);
      pick = $urandom_range(0, 7);
      link_weight = (pick == 0) ? -32768 : (pick == 1) ? 32767 : (pick == 2) ? 4096 :
                    (pick == 3) ? -4096 : int'($urandom_range(0, 65535)) - 32768;
      set_config(select_count, 1'($urandom_range(0, 1)), link_weight);
      steady_flow = (phase == 1);
      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 19);
        length = (pick == 0) ? kte_pkg::MAX_ELEMENTS : (pick < 5) ? $urandom_range(11, 40)
                                                                  : $urandom_range(1, 10);
        pick = $urandom_range(0, 9);
        spread = (pick < 6) ? SPREAD_FULL : (pick < 9) ? SPREAD_NARROW : SPREAD_EDGES;
        send_random_vector(length, (length < kte_pkg::MAX_ELEMENTS) || $urandom_range(0, 1),
                           spread);
      end
      steady_flow = 1'b0;
      phase++;
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    elem_if.valid = 1'b0;
    elem_if.activity = '0;
    elem_if.final_element = 1'b0;
    shadow_select_count = 7'd1;
    shadow_keep_smallest = 1'b0;
    shadow_link_weight = 16'sd4096;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_smallest_and_rounding();
    test_count_extremes();
    test_full_store();
    test_random_vectors();
    wait_for_results();

    $display("Sent %0d element requests in %0d vectors and checked %0d kept results.",
             requests_sent, vectors_closed, results_checked);
    $display("Covered largest and smallest modes, ties, zero and oversized counts, full stores.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/kte_pkg.sv
design/kte_ifs.sv
design/kte_ram.sv
design/kte_cfg.sv
design/kte_weigh.sv
design/keep_top_n_extremes_core.sv
test/keep_top_n_extremes_core_tb.sv
